// ===== sv/srtf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the shortest-remaining-time-first scheduler.
// Used by srtf_ctrl, srtf_dp and the top level srtf_schedule_simulator.
package srtf_pkg;

	localparam int ARR_W      = 12;
	localparam int BUR_W      = 12;
	localparam int ID_W       = 5;
	localparam int TIME_W     = 17;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 80;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	typedef struct packed {
		logic load;
		logic idx_clr;
		logic idx_inc;
		logic scan_rd;
		logic update;
		logic out_load;
		logic run_clr;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic finishing;
		logic emit_last;
		logic out_free;
	} status_t;

endpackage

// ===== sv/srtf_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the scheduler: loading, per-tick table scans,
// tick updates and record output. Depends on srtf_pkg.
module srtf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	input  srtf_pkg::status_t  status,
	output srtf_pkg::cmd_t     cmd
);

	srtf_pkg::state_t state_q;
	srtf_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srtf_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			srtf_pkg::ST_LOAD: begin
				if (in_valid && in_last) begin
					state_nxt = srtf_pkg::ST_SCAN;
				end
			end
			srtf_pkg::ST_SCAN: begin
				if (status.scan_last) begin
					state_nxt = srtf_pkg::ST_DRAIN;
				end
			end
			srtf_pkg::ST_DRAIN: begin
				state_nxt = srtf_pkg::ST_UPDATE;
			end
			srtf_pkg::ST_UPDATE: begin
				if (status.finishing) begin
					state_nxt = srtf_pkg::ST_EMIT_RD;
				end else begin
					state_nxt = srtf_pkg::ST_SCAN;
				end
			end
			srtf_pkg::ST_EMIT_RD: begin
				state_nxt = srtf_pkg::ST_EMIT_LD;
			end
			srtf_pkg::ST_EMIT_LD: begin
				if (status.out_free) begin
					if (status.emit_last) begin
						state_nxt = srtf_pkg::ST_LOAD;
					end else begin
						state_nxt = srtf_pkg::ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_nxt = srtf_pkg::ST_LOAD;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			srtf_pkg::ST_LOAD: begin
				in_ready    = 1'b1;
				cmd.load    = in_valid;
				cmd.idx_clr = in_valid && in_last;
			end
			srtf_pkg::ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.idx_inc = !status.scan_last;
			end
			srtf_pkg::ST_DRAIN: begin
				cmd = '0;
			end
			srtf_pkg::ST_UPDATE: begin
				cmd.update  = 1'b1;
				cmd.idx_clr = 1'b1;
			end
			srtf_pkg::ST_EMIT_RD: begin
				cmd = '0;
			end
			srtf_pkg::ST_EMIT_LD: begin
				cmd.out_load = status.out_free;
				cmd.idx_inc  = status.out_free && !status.emit_last;
				cmd.run_clr  = status.out_free && status.emit_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== sv/srtf_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the scheduler: process tables, tick counter, minimum search
// and the output register. Driven by srtf_ctrl; depends on srtf_pkg.
module srtf_dp #(
	parameter int MAX_PROCS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  srtf_pkg::cmd_t                   cmd,
	output srtf_pkg::status_t                status,
	input  logic [srtf_pkg::IN_DATA_W-1:0]   in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [srtf_pkg::OUT_DATA_W-1:0]  out_data,
	output logic                             out_last
);

	localparam int IDX_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W    = $clog2(MAX_PROCS + 1);
	localparam int TICK_MAX = 4095 * (MAX_PROCS + 1);
	localparam int TICK_CW  = $clog2(TICK_MAX + 1);
	localparam int TICK_W   = (TICK_CW > srtf_pkg::TIME_W) ? TICK_CW : srtf_pkg::TIME_W;
	localparam int PAD_W    = srtf_pkg::OUT_DATA_W - srtf_pkg::ID_W - 4 * srtf_pkg::TIME_W;

	logic [srtf_pkg::ARR_W-1:0]  arr_mem  [MAX_PROCS];
	logic [srtf_pkg::BUR_W-1:0]  bur_mem  [MAX_PROCS];
	logic [srtf_pkg::BUR_W-1:0]  rem_mem  [MAX_PROCS];
	logic [srtf_pkg::TIME_W-1:0] resp_mem [MAX_PROCS];
	logic [srtf_pkg::TIME_W-1:0] comp_mem [MAX_PROCS];

	logic [srtf_pkg::ARR_W-1:0]  arr_rd_q;
	logic [srtf_pkg::BUR_W-1:0]  bur_rd_q;
	logic [srtf_pkg::BUR_W-1:0]  rem_rd_q;
	logic [srtf_pkg::TIME_W-1:0] resp_rd_q;
	logic [srtf_pkg::TIME_W-1:0] comp_rd_q;

	logic [CNT_W-1:0]            loaded_q;
	logic [CNT_W-1:0]            done_q;
	logic [TICK_W-1:0]           tick_q;
	logic [IDX_W-1:0]            idx_q;
	logic [IDX_W-1:0]            idx_s1;
	logic                        rd_vld_s1;
	logic [MAX_PROCS-1:0]        started_q;
	logic                        found_q;
	logic [IDX_W-1:0]            pick_q;
	logic [srtf_pkg::BUR_W-1:0]  best_rem_q;
	logic [srtf_pkg::ARR_W-1:0]  best_arr_q;

	logic                        out_vld_q;
	logic [srtf_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                        out_last_q;

	logic [srtf_pkg::ARR_W-1:0]  in_arr;
	logic [srtf_pkg::BUR_W-1:0]  in_bur;
	logic                        store_en;
	logic [IDX_W-1:0]            load_idx;
	logic                        cand;
	logic [IDX_W:0]              id_full;
	logic [srtf_pkg::TIME_W-1:0] tat;
	logic [srtf_pkg::TIME_W-1:0] wait_t;

	assign in_arr   = in_data[srtf_pkg::ARR_W-1:0];
	// A zero burst is served as one tick so that the run always ends.
	assign in_bur   = (in_data[srtf_pkg::ARR_W +: srtf_pkg::BUR_W] == '0) ?
		srtf_pkg::BUR_W'(1) : in_data[srtf_pkg::ARR_W +: srtf_pkg::BUR_W];
	assign store_en = cmd.load && (loaded_q < CNT_W'(MAX_PROCS));
	assign load_idx = IDX_W'(loaded_q);

	// Strict less-than keeps the lowest index on equal remaining times.
	assign cand = rd_vld_s1 && (TICK_W'(arr_rd_q) <= tick_q) && (rem_rd_q != '0) &&
		(!found_q || (rem_rd_q < best_rem_q));

	assign status.scan_last = ((CNT_W'(idx_q) + CNT_W'(1)) == loaded_q);
	assign status.emit_last = ((CNT_W'(idx_q) + CNT_W'(1)) == loaded_q);
	assign status.finishing = found_q && (best_rem_q == srtf_pkg::BUR_W'(1)) &&
		((done_q + CNT_W'(1)) == loaded_q);
	assign status.out_free  = !out_vld_q || out_ready;

	always_ff @(posedge clk) begin
		if (store_en) begin
			arr_mem[load_idx] <= in_arr;
			bur_mem[load_idx] <= in_bur;
		end
		arr_rd_q <= arr_mem[idx_q];
		bur_rd_q <= bur_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			rem_mem[load_idx] <= in_bur;
		end else if (cmd.update && found_q) begin
			rem_mem[pick_q] <= best_rem_q - srtf_pkg::BUR_W'(1);
		end
		rem_rd_q <= rem_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.update && found_q && !started_q[pick_q]) begin
			resp_mem[pick_q] <= srtf_pkg::TIME_W'(tick_q - TICK_W'(best_arr_q));
		end
		if (cmd.update && found_q && (best_rem_q == srtf_pkg::BUR_W'(1))) begin
			comp_mem[pick_q] <= srtf_pkg::TIME_W'(tick_q + TICK_W'(1));
		end
		resp_rd_q <= resp_mem[idx_q];
		comp_rd_q <= comp_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= '0;
			done_q    <= '0;
			tick_q    <= '0;
			idx_q     <= '0;
			idx_s1    <= '0;
			rd_vld_s1 <= 1'b0;
			started_q <= '0;
			found_q   <= 1'b0;
			pick_q    <= '0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			idx_s1    <= idx_q;
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (store_en) begin
				loaded_q            <= loaded_q + CNT_W'(1);
				started_q[load_idx] <= 1'b0;
			end
			if (cand) begin
				found_q <= 1'b1;
				pick_q  <= idx_s1;
			end
			if (cmd.update) begin
				found_q <= 1'b0;
				tick_q  <= tick_q + TICK_W'(1);
				if (found_q) begin
					started_q[pick_q] <= 1'b1;
					if (best_rem_q == srtf_pkg::BUR_W'(1)) begin
						done_q <= done_q + CNT_W'(1);
					end
				end
			end
			if (cmd.run_clr) begin
				loaded_q  <= '0;
				done_q    <= '0;
				tick_q    <= '0;
				started_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cand) begin
			best_rem_q <= rem_rd_q;
			best_arr_q <= arr_rd_q;
		end
	end

	// Differences are taken modulo the record field width.
	assign id_full = {1'b0, idx_q} + (IDX_W + 1)'(1);
	assign tat     = comp_rd_q - srtf_pkg::TIME_W'(arr_rd_q);
	assign wait_t  = tat - srtf_pkg::TIME_W'(bur_rd_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {PAD_W'(0), resp_rd_q, wait_t, tat, comp_rd_q,
				srtf_pkg::ID_W'(id_full)};
			out_last_q <= status.emit_last;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

// ===== sv/srtf_schedule_simulator.sv =====
`timescale 1ns / 1ps
// Top level of the shortest-remaining-time-first schedule simulator.
// Instantiates srtf_ctrl and srtf_dp; depends on srtf_pkg.
//
// Usage: process descriptors enter on the s_ stream, one transaction per
// cycle while s_tready is high; s_tdata holds arrival and burst, s_tlast
// ends the set. Descriptors beyond MAX_PROCS are dropped. On the last one
// s_tready falls and the block simulates ticks from zero: every tick walks
// the table through one memory read port, then ends in a drain and an update state.
// Then one record per process, in load order, leaves on the m_ stream, with
// m_tlast on the final record; each record is read, then loaded into the
// record register once that register is free. The record register lets
// the last record wait while s_tready is high again and the next set loads.
// Reset empties the table, zeroes the tick and leaves the block ready to
// load. A stalled receiver freezes the record output and the emission of
// further records.
module srtf_schedule_simulator #(
	parameter int MAX_PROCS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [srtf_pkg::IN_DATA_W-1:0]   s_tdata,  // arrival[11:0], burst[23:12]
	input  logic                             s_tlast,  // final_entry
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [srtf_pkg::OUT_DATA_W-1:0]  m_tdata,  // process_id[4:0], completion[21:5],
	                                                   // turnaround[38:22], waiting[55:39],
	                                                   // response[72:56], zero[79:73]
	output logic                             m_tlast   // last_record
);

	srtf_pkg::cmd_t    cmd;
	srtf_pkg::status_t status;

	srtf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	srtf_dp #(
		.MAX_PROCS (MAX_PROCS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

// ===== bench/tb_srtf_schedule_simulator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for srtf_schedule_simulator: directed and random descriptor sets,
// checked record by record against a scheduler model kept inside the bench.
// Depends on srtf_pkg and the srtf_schedule_simulator RTL.
module tb_srtf_schedule_simulator;

	localparam int TBL_DEPTH  = 16;
	localparam int LONG_HOLD  = 300;
	localparam int DIRECTED_N = 25;
	localparam int RANDOM_N   = 225;

	typedef struct packed {
		logic [srtf_pkg::ARR_W-1:0] arrival;
		logic [srtf_pkg::BUR_W-1:0] burst;
		logic                       final_entry;
		logic [3:0]                 gap;
		logic                       drain_first;
	} descriptor_t;

	typedef struct packed {
		logic [srtf_pkg::ID_W-1:0]   pid;
		logic [srtf_pkg::TIME_W-1:0] completion;
		logic [srtf_pkg::TIME_W-1:0] turnaround;
		logic [srtf_pkg::TIME_W-1:0] waiting;
		logic [srtf_pkg::TIME_W-1:0] response;
		logic                        last_rec;
	} sched_record_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [srtf_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic                            s_tlast = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [srtf_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            m_tlast;

	descriptor_t   descriptor_queue[$];
	sched_record_t sched_records_due[$];

	// Scheduler model state: the descriptor table of the set being loaded.
	int tbl_arrival[TBL_DEPTH];
	int tbl_burst[TBL_DEPTH];
	int tbl_count = 0;

	int total_items = 0;
	int sent_items = 0;
	int mismatch_count = 0;
	bit sender_calm = 1'b0;

	srtf_schedule_simulator #(
		.MAX_PROCS(TBL_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// Preemptive SRTF over the loaded table, one tick at a time from tick zero.
	task automatic run_srtf_schedule();
		int remaining[TBL_DEPTH];
		int first_run[TBL_DEPTH];
		int finish_tick[TBL_DEPTH];
		int finished;
		int tick;
		int pick;
		int turn;
		int k;
		sched_record_t rec;
		for (k = 0; k < tbl_count; k++) begin
			remaining[k] = tbl_burst[k];
			first_run[k] = -1;
		end
		finished = 0;
		tick = 0;
		while (finished < tbl_count) begin
			pick = -1;
			for (k = 0; k < tbl_count; k++) begin
				if (tbl_arrival[k] <= tick && remaining[k] > 0 &&
				    (pick < 0 || remaining[k] < remaining[pick]))
					pick = k;
			end
			tick++;
			if (pick >= 0) begin
				if (first_run[pick] < 0)
					first_run[pick] = tick - 1 - tbl_arrival[pick];
				remaining[pick]--;
				if (remaining[pick] == 0) begin
					finish_tick[pick] = tick;
					finished++;
				end
			end
		end
		for (k = 0; k < tbl_count; k++) begin
			turn = finish_tick[k] - tbl_arrival[k];
			rec.pid = srtf_pkg::ID_W'(k + 1);
			rec.completion = srtf_pkg::TIME_W'(finish_tick[k]);
			rec.turnaround = srtf_pkg::TIME_W'(turn);
			rec.waiting = srtf_pkg::TIME_W'(turn - tbl_burst[k]);
			rec.response = srtf_pkg::TIME_W'(first_run[k]);
			rec.last_rec = (k == tbl_count - 1);
			sched_records_due.push_back(rec);
		end
		tbl_count = 0;
	endtask

	task automatic load_descriptor(input logic [srtf_pkg::ARR_W-1:0] arr,
	                               input logic [srtf_pkg::BUR_W-1:0] bur,
	                               input logic fin);
		// Descriptors past the table depth are dropped, but a final one still ends the set.
		if (tbl_count < TBL_DEPTH) begin
			tbl_arrival[tbl_count] = int'(arr);
			tbl_burst[tbl_count] = (bur == '0) ? 1 : int'(bur);
			tbl_count++;
		end
		if (fin)
			run_srtf_schedule();
	endtask

	task automatic add_descriptor(input int arr, input int bur, input bit fin, input bit drain);
		descriptor_t d;
		d.arrival = srtf_pkg::ARR_W'(arr);
		d.burst = srtf_pkg::BUR_W'(bur);
		d.final_entry = fin;
		d.gap = sender_calm ? 4'd0 : 4'($urandom_range(0, 13));
		d.drain_first = drain;
		descriptor_queue.push_back(d);
		total_items++;
	endtask

	// Sender: offers queued descriptors, holding each until the block takes it.
	descriptor_t next_desc;
	int          idle_cnt = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			idle_cnt = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				load_descriptor(s_tdata[srtf_pkg::ARR_W-1:0],
					s_tdata[srtf_pkg::ARR_W +: srtf_pkg::BUR_W], s_tlast);
				sent_items++;
			end
			if (!s_tvalid || s_tready) begin
				if (descriptor_queue.size() != 0)
					next_desc = descriptor_queue[0];
				if (descriptor_queue.size() != 0 && idle_cnt >= int'(next_desc.gap) &&
				    (!next_desc.drain_first || sched_records_due.size() == 0)) begin
					void'(descriptor_queue.pop_front());
					s_tdata <= {next_desc.burst, next_desc.arrival};
					s_tlast <= next_desc.final_entry;
					s_tvalid <= 1'b1;
					idle_cnt = 0;
				end else begin
					s_tvalid <= 1'b0;
					if (descriptor_queue.size() != 0)
						idle_cnt++;
				end
			end
		end
	end

	// Receiver: checks each record transaction, then stalls for a random count.
	sched_record_t want;
	int            rec_count = 0;
	int            stall_cnt = 0;
	int            hold_cnt = 0;
	bit            recv_calm = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_cnt = 0;
			hold_cnt = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (sched_records_due.size() == 0) begin
					report_mismatch($sformatf("record with no expectation, tdata %h", m_tdata));
				end else begin
					want = sched_records_due.pop_front();
					if (m_tdata[4:0] !== want.pid)
						report_mismatch($sformatf("process_id got %0d want %0d",
							m_tdata[4:0], want.pid));
					if (m_tdata[21:5] !== want.completion)
						report_mismatch($sformatf("pid %0d completion got %0d want %0d",
							want.pid, m_tdata[21:5], want.completion));
					if (m_tdata[38:22] !== want.turnaround)
						report_mismatch($sformatf("pid %0d turnaround got %0d want %0d",
							want.pid, m_tdata[38:22], want.turnaround));
					if (m_tdata[55:39] !== want.waiting)
						report_mismatch($sformatf("pid %0d waiting got %0d want %0d",
							want.pid, m_tdata[55:39], want.waiting));
					if (m_tdata[72:56] !== want.response)
						report_mismatch($sformatf("pid %0d response got %0d want %0d",
							want.pid, m_tdata[72:56], want.response));
					if (m_tdata[79:73] !== '0)
						report_mismatch($sformatf("pid %0d padding bits %h not zero",
							want.pid, m_tdata[79:73]));
					if (m_tlast !== want.last_rec)
						report_mismatch($sformatf("pid %0d last_record got %b want %b",
							want.pid, m_tlast, want.last_rec));
				end
				rec_count++;
				if (rec_count % 24 == 0)
					recv_calm = ($urandom_range(0, 3) == 0);
				// Twice in a run the receiver goes quiet long enough to back up the input.
				if (rec_count % 113 == 37)
					hold_cnt = LONG_HOLD;
				stall_cnt = recv_calm ? 0 : $urandom_range(0, 13);
			end else if (hold_cnt > 0) begin
				hold_cnt--;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
			end
			m_tready <= (hold_cnt == 0 && stall_cnt == 0);
		end
	end

	initial begin
		#100_000_000;
		$display("simulation failed");
		$finish;
	end

	int  k;
	int  set_len;
	int  arr;
	int  bur;
	int  wide_left;
	bit  drain;

	initial begin
		// Single process, shortest possible run.
		add_descriptor(0, 1, 1'b1, 1'b0);
		// All bits set: late arrival, longest burst.
		add_descriptor(4095, 4095, 1'b1, 1'b1);
		// A zero burst is served as one tick.
		add_descriptor(0, 0, 1'b0, 1'b0);
		add_descriptor(2, 3, 1'b1, 1'b0);
		// Preemption, a tie broken by the lower index, and idle ticks before the last arrival.
		add_descriptor(0, 8, 1'b0, 1'b0);
		add_descriptor(1, 4, 1'b0, 1'b0);
		add_descriptor(1, 4, 1'b0, 1'b0);
		add_descriptor(30, 2, 1'b1, 1'b0);
		// Seventeen descriptors: the last one is dropped but still closes the set.
		for (k = 0; k < TBL_DEPTH + 1; k++)
			add_descriptor(k, (k % 5) + 1, k == TBL_DEPTH, 1'b0);

		wide_left = 3;
		while (total_items < DIRECTED_N + RANDOM_N) begin
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 20)
			                                      : $urandom_range(1, 16);
			sender_calm = ($urandom_range(0, 3) == 0);
			drain = (total_items == DIRECTED_N) || ($urandom_range(0, 7) == 0);
			for (k = 0; k < set_len; k++) begin
				arr = $urandom_range(0, 40);
				bur = ($urandom_range(0, 29) == 0) ? 0 : $urandom_range(1, 15);
				// A few full-range values; most stay small to keep the tick count down.
				if (wide_left > 0 && $urandom_range(0, 60) == 0) begin
					wide_left--;
					if ($urandom_range(0, 1))
						arr = $urandom_range(0, 4095);
					else
						bur = $urandom_range(0, 4095);
				end
				add_descriptor(arr, bur, k == set_len - 1, drain && k == 0);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (sent_items != total_items || sched_records_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
